// ===== src/cpci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpci_pkg - shared types and constants for the circle pair impulse block
// Fixed-point format, queue sizing, item and result records, output clamp.
// ----------------------------------------------------------------------------
package cpci_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_BITS  = 32;
	localparam int IN_BITS    = 288;
	localparam int OUT_BITS   = 4 * WORD_BITS;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// 1.0 in Q1.16, the clamp value of a normal component
	localparam logic [FRAC_BITS:0] NORM_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	typedef struct packed {
		logic               overlap;
		logic               go;
		logic [63:0]        d2;
		logic               dx_neg;
		logic [31:0]        dx_mag;
		logic               dy_neg;
		logic [31:0]        dy_mag;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [31:0]        ma;
		logic [31:0]        mb;
		logic [16:0]        e;
	} pair_t;

	typedef struct packed {
		logic                 overlap;
		logic                 impulse_valid;
		logic [WORD_BITS-1:0] pax;
		logic [WORD_BITS-1:0] pay;
		logic [WORD_BITS-1:0] pbx;
		logic [WORD_BITS-1:0] pby;
	} result_t;

	typedef struct packed {
		logic [FIFO_AW:0] level;
		logic             not_empty;
	} fifo_stat_t;

	// magnitude plus sign to a saturated two's complement word
	function automatic logic [WORD_BITS-1:0] sat_word(input logic [51:0] m, input logic neg);
		logic [51:0] half;
		half = 52'(1) << (WORD_BITS - 1);
		if (neg) begin
			if (m > half)
				sat_word = half[WORD_BITS-1:0];
			else
				sat_word = WORD_BITS'(52'(0) - m);
		end else begin
			if (m > half - 52'(1))
				sat_word = WORD_BITS'(half - 52'(1));
			else
				sat_word = WORD_BITS'(m);
		end
	endfunction

endpackage

// ===== src/cpci_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpci_sqrt - pipelined integer square root
// One result bit per stage, floor(sqrt(x)) of a 64-bit value after 32 stages.
// ----------------------------------------------------------------------------
module cpci_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] x,
	output logic [31:0] root
);

	localparam int ST = 32;

	logic [63:0] rem_q [ST-1];
	logic [63:0] res_q [ST];

	genvar i;
	for (i = 0; i < ST; i++) begin : g_st
		logic [63:0] rem_in, res_in, bit_c, trial;
		if (i == 0) begin : g_first
			assign rem_in = x;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign res_in = res_q[i-1];
		end
		assign bit_c = 64'(1) << (2 * (ST - 1 - i));
		assign trial = res_in + bit_c;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial)
					res_q[i] <= (res_in >> 1) + bit_c;
				else
					res_q[i] <= res_in >> 1;
			end
		end

		if (i < ST - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					if (rem_in >= trial)
						rem_q[i] <= rem_in - trial;
					else
						rem_q[i] <= rem_in;
				end
			end
		end
	end

	assign root = res_q[ST-1][31:0];

endmodule

// ===== src/cpci_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpci_div - pipelined restoring divider
// One quotient bit per stage, MSB first; quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module cpci_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [CW-1:0] rem_q [QW-1];
	logic [DW-1:0] den_q [QW-1];
	logic [QW-1:0] quo_q [QW];

	genvar i;
	for (i = 0; i < QW; i++) begin : g_st
		logic [CW-1:0] rem_in, trial;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic          take;
		if (i == 0) begin : g_first
			assign rem_in = CW'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign den_in = den_q[i-1];
			assign quo_in = quo_q[i-1];
		end
		assign trial = CW'(den_in) << (QW - 1 - i);
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en)
				quo_q[i] <= take ? (quo_in | (QW'(1) << (QW - 1 - i))) : quo_in;
		end

		if (i < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i] <= take ? rem_in - trial : rem_in;
					den_q[i] <= den_in;
				end
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

// ===== src/cpci_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpci_front - input stage
// Takes a pair, squares distance and radius sum, flags overlap, queues it.
// ----------------------------------------------------------------------------
module cpci_front import cpci_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_BITS-1:0] s_tdata,
	input  logic               s_tuser,
	input  fifo_stat_t         stat,
	output logic               push,
	output pair_t              item
);

	logic        v_s1, v_s2, accept;
	logic        dx_neg_s1, dy_neg_s1, bod_s1;
	logic [31:0] dx_mag_s1, dy_mag_s1, rs_s1, ma_s1, mb_s1;
	logic signed [31:0] vx_s1, vy_s1;
	logic [16:0] e_s1;
	logic [31:0] rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y, mass_a, mass_b;
	logic [30:0] radius_a, radius_b;
	logic [16:0] bounce_a, bounce_b;
	logic [63:0] dx2_s2, dy2_s2, rs2_s2, d2;
	pair_t       car_s2;

	assign rel_pos_x = s_tdata[31:0];
	assign rel_pos_y = s_tdata[63:32];
	assign rel_vel_x = s_tdata[95:64];
	assign rel_vel_y = s_tdata[127:96];
	assign radius_a  = s_tdata[158:128];
	assign radius_b  = s_tdata[189:159];
	assign mass_a    = s_tdata[221:190];
	assign mass_b    = s_tdata[253:222];
	assign bounce_a  = s_tdata[270:254];
	assign bounce_b  = s_tdata[287:271];

	// room for this item and everything still on its way to the queue
	assign s_tready = (5'(stat.level) + 5'(v_s1) + 5'(v_s2)) < 5'(FIFO_DEPTH);
	assign accept   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_neg_s1 <= rel_pos_x[31];
		dy_neg_s1 <= rel_pos_y[31];
		dx_mag_s1 <= rel_pos_x[31] ? 32'(0) - rel_pos_x : rel_pos_x;
		dy_mag_s1 <= rel_pos_y[31] ? 32'(0) - rel_pos_y : rel_pos_y;
		vx_s1     <= signed'(rel_vel_x);
		vy_s1     <= signed'(rel_vel_y);
		rs_s1     <= 32'(radius_a) + 32'(radius_b);
		ma_s1     <= mass_a;
		mb_s1     <= mass_b;
		e_s1      <= (bounce_a < bounce_b) ? bounce_a : bounce_b;
		bod_s1    <= s_tuser;
	end

	always_ff @(posedge clk) begin
		dx2_s2         <= dx_mag_s1 * dx_mag_s1;
		dy2_s2         <= dy_mag_s1 * dy_mag_s1;
		rs2_s2         <= rs_s1 * rs_s1;
		car_s2.overlap <= 1'b0;
		car_s2.go      <= bod_s1;
		car_s2.d2      <= '0;
		car_s2.dx_neg  <= dx_neg_s1;
		car_s2.dx_mag  <= dx_mag_s1;
		car_s2.dy_neg  <= dy_neg_s1;
		car_s2.dy_mag  <= dy_mag_s1;
		car_s2.vx      <= vx_s1;
		car_s2.vy      <= vy_s1;
		car_s2.ma      <= ma_s1;
		car_s2.mb      <= mb_s1;
		car_s2.e       <= e_s1;
	end

	assign d2 = dx2_s2 + dy2_s2;

	always_comb begin
		item         = car_s2;
		item.d2      = d2;
		item.overlap = rs2_s2 > d2;
		item.go      = car_s2.go & (rs2_s2 > d2);
	end

	assign push = v_s2;

endmodule

// ===== src/cpci_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpci_fifo - item queue between front and back
// Small register queue; the head is visible while not empty.
// ----------------------------------------------------------------------------
module cpci_fifo import cpci_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pair_t      wr_item,
	input  logic       pop,
	output pair_t      head,
	output fifo_stat_t stat
);

	pair_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_item;
	end

	assign head           = mem_q[rd_q];
	assign stat.level     = cnt_q;
	assign stat.not_empty = cnt_q != '0;

endmodule

// ===== src/cpci_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpci_back - impulse pipeline
// Normal by root and division, mass shares by division, impulse products,
// saturation. All stages move together on en.
// ----------------------------------------------------------------------------
module cpci_back import cpci_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  pair_t   in_item,
	output logic    out_valid,
	output result_t out_res
);

	localparam int SQ_ST  = 32;
	localparam int ND_ST  = FRAC_BITS + 1;
	localparam int MU_ST  = 32;
	localparam int LAT    = SQ_ST + ND_ST + 7;
	localparam int RA_WT  = MU_ST + 1 - ND_ST;
	localparam int W_WT   = LAT - 4 - (MU_ST + 2);
	localparam int SIDE_N = SQ_ST + ND_ST;

	typedef struct packed {
		logic               overlap;
		logic               go;
		logic               dx_neg;
		logic               dy_neg;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [16:0]        e;
	} side_t;

	logic [LAT-1:0] v_q;
	side_t          side_in;
	side_t          side_q [SIDE_N];
	logic [63:0]    dmag_q [SQ_ST];
	logic [31:0]    len;
	logic           lz_q [ND_ST];
	logic [ND_ST-1:0] qx, qy, nxm, nym;

	logic [63:0]    mm_s1;
	logic [32:0]    msum, msum_s1;
	logic [31:0]    mu;
	logic [ND_ST-1:0] ra, rb;
	logic [2*ND_ST-1:0] ra_q [RA_WT];
	logic           mz_q [MU_ST];
	logic [48:0]    wa_full, wb_full;
	logic [31:0]    wa_s34, wb_s34;
	logic [63:0]    wq [W_WT];

	logic signed [17:0] nx_c, ny_c;
	logic signed [49:0] px_s50, py_s50;
	logic [ND_ST-1:0]   nxm_s50, nym_s50, nxm_s51, nym_s51, nxm_s52, nym_s52;
	logic [ND_ST-1:0]   nxm_s53, nym_s53, nxm_s54, nym_s54;
	side_t              side_s50, side_s51, side_s52, side_s53, side_s54, side_s55;
	logic signed [50:0] s_sum;
	logic signed [34:0] vn;
	logic [32:0]        vmag_s51;
	logic               np_s51, np_s52, np_s53, np_s54, np_s55;
	logic [34:0]        kk_s52;
	logic [17:0]        fac;
	logic [50:0]        kprod;
	logic [49:0]        pal_s53, pbl_s53;
	logic [48:0]        pah_s53, pbh_s53;
	logic [66:0]        fa, fb;
	logic [50:0]        sa_s54, sb_s54;
	logic [67:0]        pax_f, pay_f, pbx_f, pby_f;
	logic [51:0]        qax_s55, qay_s55, qbx_s55, qby_s55;
	logic               iv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[LAT-2:0], in_valid};
	end
	assign out_valid = v_q[LAT-1];

	assign side_in.overlap = in_item.overlap;
	assign side_in.go      = in_item.go;
	assign side_in.dx_neg  = in_item.dx_neg;
	assign side_in.dy_neg  = in_item.dy_neg;
	assign side_in.vx      = in_item.vx;
	assign side_in.vy      = in_item.vy;
	assign side_in.e       = in_item.e;

	// delay lines that keep side data beside the long units
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int k = 1; k < SIDE_N; k++)
				side_q[k] <= side_q[k-1];
			dmag_q[0] <= {in_item.dx_mag, in_item.dy_mag};
			for (int k = 1; k < SQ_ST; k++)
				dmag_q[k] <= dmag_q[k-1];
			lz_q[0] <= len == '0;
			for (int k = 1; k < ND_ST; k++)
				lz_q[k] <= lz_q[k-1];
			ra_q[0] <= {ra, rb};
			for (int k = 1; k < RA_WT; k++)
				ra_q[k] <= ra_q[k-1];
			mz_q[0] <= msum_s1 == '0;
			for (int k = 1; k < MU_ST; k++)
				mz_q[k] <= mz_q[k-1];
			wq[0] <= {wa_s34, wb_s34};
			for (int k = 1; k < W_WT; k++)
				wq[k] <= wq[k-1];
		end
	end

	// normal direction
	cpci_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (in_item.d2),
		.root (len)
	);

	cpci_div #(.NW(32 + FRAC_BITS), .DW(32), .QW(ND_ST)) u_div_nx (
		.clk (clk),
		.en  (en),
		.num ({dmag_q[SQ_ST-1][63:32], {FRAC_BITS{1'b0}}}),
		.den (len),
		.quo (qx)
	);

	cpci_div #(.NW(32 + FRAC_BITS), .DW(32), .QW(ND_ST)) u_div_ny (
		.clk (clk),
		.en  (en),
		.num ({dmag_q[SQ_ST-1][31:0], {FRAC_BITS{1'b0}}}),
		.den (len),
		.quo (qy)
	);

	// mass shares
	assign msum = 33'(in_item.ma) + 33'(in_item.mb);

	always_ff @(posedge clk) begin
		if (en) begin
			mm_s1   <= in_item.ma * in_item.mb;
			msum_s1 <= msum;
		end
	end

	cpci_div #(.NW(64), .DW(33), .QW(32)) u_div_mu (
		.clk (clk),
		.en  (en),
		.num (mm_s1),
		.den (msum_s1),
		.quo (mu)
	);

	cpci_div #(.NW(32 + FRAC_BITS), .DW(33), .QW(ND_ST)) u_div_ra (
		.clk (clk),
		.en  (en),
		.num ({in_item.mb, {FRAC_BITS{1'b0}}}),
		.den (msum),
		.quo (ra)
	);

	cpci_div #(.NW(32 + FRAC_BITS), .DW(33), .QW(ND_ST)) u_div_rb (
		.clk (clk),
		.en  (en),
		.num ({in_item.ma, {FRAC_BITS{1'b0}}}),
		.den (msum),
		.quo (rb)
	);

	assign wa_full = mu * ra_q[RA_WT-1][2*ND_ST-1:ND_ST];
	assign wb_full = mu * ra_q[RA_WT-1][ND_ST-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			wa_s34 <= mz_q[MU_ST-1] ? '0 : wa_full[FRAC_BITS+31:FRAC_BITS];
			wb_s34 <= mz_q[MU_ST-1] ? '0 : wb_full[FRAC_BITS+31:FRAC_BITS];
		end
	end

	// normal components, zero when the distance is zero
	assign nxm  = lz_q[ND_ST-1] ? '0 : ((qx > NORM_ONE) ? NORM_ONE : qx);
	assign nym  = lz_q[ND_ST-1] ? '0 : ((qy > NORM_ONE) ? NORM_ONE : qy);
	assign nx_c = side_q[SIDE_N-1].dx_neg ? -signed'({1'b0, nxm}) : signed'({1'b0, nxm});
	assign ny_c = side_q[SIDE_N-1].dy_neg ? -signed'({1'b0, nym}) : signed'({1'b0, nym});

	// vn = floor(s / 2^F); approaching when s < 2^F
	assign s_sum = {px_s50[49], px_s50} + {py_s50[49], py_s50};
	assign vn    = s_sum[50:FRAC_BITS];
	assign fac   = 18'(NORM_ONE) + 18'(side_s51.e);
	assign kprod = fac * vmag_s51;
	assign fa    = {pah_s53, 18'b0} + 67'(pal_s53);
	assign fb    = {pbh_s53, 18'b0} + 67'(pbl_s53);
	assign pax_f = sa_s54 * nxm_s54;
	assign pay_f = sa_s54 * nym_s54;
	assign pbx_f = sb_s54 * nxm_s54;
	assign pby_f = sb_s54 * nym_s54;
	assign iv    = side_s55.go & np_s55;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s50   <= side_q[SIDE_N-1].vx * nx_c;
			py_s50   <= side_q[SIDE_N-1].vy * ny_c;
			nxm_s50  <= nxm;
			nym_s50  <= nym;
			side_s50 <= side_q[SIDE_N-1];

			vmag_s51 <= 33'(35'(0) - vn);
			np_s51   <= s_sum[50] | (s_sum[50:FRAC_BITS] == '0);
			nxm_s51  <= nxm_s50;
			nym_s51  <= nym_s50;
			side_s51 <= side_s50;

			kk_s52   <= kprod[50:FRAC_BITS];
			np_s52   <= np_s51;
			nxm_s52  <= nxm_s51;
			nym_s52  <= nym_s51;
			side_s52 <= side_s51;

			pal_s53  <= kk_s52[17:0] * wq[W_WT-1][63:32];
			pah_s53  <= kk_s52[34:18] * wq[W_WT-1][63:32];
			pbl_s53  <= kk_s52[17:0] * wq[W_WT-1][31:0];
			pbh_s53  <= kk_s52[34:18] * wq[W_WT-1][31:0];
			np_s53   <= np_s52;
			nxm_s53  <= nxm_s52;
			nym_s53  <= nym_s52;
			side_s53 <= side_s52;

			sa_s54   <= fa[66:FRAC_BITS];
			sb_s54   <= fb[66:FRAC_BITS];
			np_s54   <= np_s53;
			nxm_s54  <= nxm_s53;
			nym_s54  <= nym_s53;
			side_s54 <= side_s53;

			qax_s55  <= pax_f[67:FRAC_BITS];
			qay_s55  <= pay_f[67:FRAC_BITS];
			qbx_s55  <= pbx_f[67:FRAC_BITS];
			qby_s55  <= pby_f[67:FRAC_BITS];
			np_s55   <= np_s54;
			side_s55 <= side_s54;

			out_res.overlap       <= side_s55.overlap;
			out_res.impulse_valid <= iv;
			out_res.pax <= iv ? sat_word(qax_s55, side_s55.dx_neg) : '0;
			out_res.pay <= iv ? sat_word(qay_s55, side_s55.dy_neg) : '0;
			out_res.pbx <= iv ? sat_word(qbx_s55, !side_s55.dx_neg) : '0;
			out_res.pby <= iv ? sat_word(qby_s55, !side_s55.dy_neg) : '0;
		end
	end

endmodule

// ===== src/circle_pair_collision_impulse.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle; the back pipeline advances whenever its output
//   register is empty or taken, and an 8-entry queue lets the front keep accepting.
// Reset: arst_n clears all valid flags and queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
// circle_pair_collision_impulse - top level
// Circle pair overlap test and impulse shares, streaming in and out.
// ----------------------------------------------------------------------------
module circle_pair_collision_impulse import cpci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y, radius_a, radius_b,
	// mass_a, mass_b, bounce_a, bounce_b
	input  logic [IN_BITS-1:0]  s_tdata,
	// both_have_bodies
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// push_a_x, push_a_y, push_b_x, push_b_y
	output logic [OUT_BITS-1:0] m_tdata,
	// overlap, impulse_valid
	output logic [1:0]          m_tuser
);

	fifo_stat_t stat;
	pair_t      fr_item, head;
	logic       push, pop, en;
	result_t    res;

	cpci_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.push     (push),
		.item     (fr_item)
	);

	cpci_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (fr_item),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	assign en  = !m_tvalid | m_tready;
	assign pop = en & stat.not_empty;

	cpci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (stat.not_empty),
		.in_item   (head),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	assign m_tdata = {res.pby, res.pbx, res.pay, res.pax};
	assign m_tuser = {res.impulse_valid, res.overlap};

endmodule

// ===== src/cpci_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpci_chk - port checker
// Output-side properties of the impulse block, bound to the top level.
// ----------------------------------------------------------------------------
module cpci_chk import cpci_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OUT_BITS-1:0] m_tdata,
	input logic [1:0]          m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_valid_needs_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("impulse without overlap");

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata == '0)
		else $error("nonzero push on invalid impulse");

	a_opposite_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:0] != '0) && (m_tdata[95:64] != '0)
		|-> m_tdata[31] != m_tdata[95])
		else $error("push x shares not opposed");

endmodule

bind circle_pair_collision_impulse cpci_chk u_chk (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stream bench for the circle pair collision impulse block
// Directed and random circle pairs are sent through a bursty driver; a
// bit-exact impulse predictor fills a queue of expected results that the
// monitor checks field by field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import cpci_pkg::*;

	localparam int N_RANDOM   = 450;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_AT    = 150;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		logic signed [31:0] px, py, vx, vy;
		logic [30:0]        ra, rb;
		logic [31:0]        ma, mb;
		logic [16:0]        ba, bb;
		logic               bodies;
	} pair_in_t;

	typedef struct {
		logic        overlap, valid;
		logic [31:0] pax, pay, pbx, pby;
	} impulse_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tuser = 0;
	logic [IN_BITS-1:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0;
	logic [OUT_BITS-1:0] m_tdata;
	logic [1:0] m_tuser;

	pair_in_t pending_pairs[$];
	impulse_t expected_impulses[$];
	pair_in_t cur_pair;
	int n_sent = 0, n_res = 0, n_err = 0, n_valid = 0, n_overlap = 0, n_total = 0;
	int gap_left = 0, burst_left = 4, phase_left = 0, hold_left = 0, idle_cycles = 0;
	bit held = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	circle_pair_collision_impulse dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// floor(a*b / 2^F), clamped to 2^63-1
	function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b);
		logic [127:0] r;
		r = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
		return (r > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : r[63:0];
	endfunction

	function automatic longint unit_axis(longint c, logic [63:0] len);
		logic [63:0] q;
		q = ((c < 0 ? -c : c) << FRAC_BITS) / len;
		if (q > (64'd1 << FRAC_BITS))
			q = 64'd1 << FRAC_BITS;
		return c < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] clamp_word(logic [63:0] m, bit neg);
		if (neg)
			return (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
		return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	function automatic impulse_t resolve_pair(pair_in_t p);
		impulse_t r;
		longint dx, dy, nx, ny, s, vn;
		logic [63:0] adx, ady, d2, rs, len, x, bit_v, e, kk, msum, mu, wa, wb, sa, sb;
		dx = p.px; dy = p.py;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		d2 = adx * adx + ady * ady;
		rs = 64'(p.ra) + 64'(p.rb);
		r = '{default: '0};
		r.overlap = (rs * rs) > d2;
		if (r.overlap && p.bodies) begin
			// integer square root of the squared distance
			x = d2; len = 0; bit_v = 64'd1 << 62;
			while (bit_v > x) bit_v >>= 2;
			while (bit_v != 0) begin
				if (x >= len + bit_v) begin
					x -= len + bit_v;
					len = (len >> 1) + bit_v;
				end else begin
					len >>= 1;
				end
				bit_v >>= 2;
			end
			nx = 0; ny = 0;
			if (len != 0) begin
				nx = unit_axis(dx, len);
				ny = unit_axis(dy, len);
			end
			s = longint'(p.vx) * nx + longint'(p.vy) * ny;
			if (s >= 0) vn = s >>> FRAC_BITS;
			else vn = -((-s + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS);
			if (vn <= 0) begin
				e = (p.ba < p.bb) ? p.ba : p.bb;
				kk = mul_frac((64'd1 << FRAC_BITS) + e, -vn);
				msum = 64'(p.ma) + 64'(p.mb);
				wa = 0; wb = 0;
				r.valid = 1;
				if (msum != 0) begin
					mu = (64'(p.ma) * 64'(p.mb)) / msum;
					wa = mul_frac(mu, (64'(p.mb) << FRAC_BITS) / msum);
					wb = mul_frac(mu, (64'(p.ma) << FRAC_BITS) / msum);
				end
				sa = mul_frac(kk, wa);
				sb = mul_frac(kk, wb);
				r.pax = clamp_word(mul_frac(sa, nx < 0 ? -nx : nx), nx < 0);
				r.pay = clamp_word(mul_frac(sa, ny < 0 ? -ny : ny), ny < 0);
				r.pbx = clamp_word(mul_frac(sb, nx < 0 ? -nx : nx), nx > 0);
				r.pby = clamp_word(mul_frac(sb, ny < 0 ? -ny : ny), ny > 0);
			end
		end
		return r;
	endfunction

	function automatic pair_in_t mk_pair(longint px, longint py, longint vx, longint vy,
			longint ra, longint rb, longint ma, longint mb, int ba, int bb, bit bodies);
		pair_in_t p;
		p.px = px; p.py = py; p.vx = vx; p.vy = vy;
		p.ra = ra; p.rb = rb; p.ma = ma; p.mb = mb;
		p.ba = ba; p.bb = bb; p.bodies = bodies;
		return p;
	endfunction

	function automatic longint rand_signed(int sh);
		longint v;
		v = $urandom_range(0, 32'd1 << sh);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic pair_in_t rand_pair();
		pair_in_t p;
		int sh, vsh;
		longint vm;
		if ($urandom_range(0, 9) < 2) begin
			// noise over the full field ranges, bounce factors at most 65536
			p = mk_pair($signed($urandom), $signed($urandom), $signed($urandom),
				$signed($urandom), $urandom & 31'h7FFF_FFFF, $urandom & 31'h7FFF_FFFF,
				$urandom, $urandom, $urandom_range(0, 65536), $urandom_range(0, 65536),
				$urandom_range(0, 1));
		end else begin
			sh = $urandom_range(2, 28);
			vsh = $urandom_range(2, 30);
			p = mk_pair(rand_signed(sh), rand_signed(sh), 0, 0,
				$urandom_range(0, 32'd1 << sh), $urandom_range(0, 32'd1 << sh),
				$urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 31),
				$urandom_range(0, 65536), $urandom_range(0, 65536),
				$urandom_range(0, 9) != 0);
			// mostly approaching: velocity against the offset
			vm = $urandom_range(0, 32'd1 << vsh);
			p.vx = ($urandom_range(0, 4) == 0) ? rand_signed(vsh) : (p.px < 0 ? vm : -vm);
			vm = $urandom_range(0, 32'd1 << vsh);
			p.vy = ($urandom_range(0, 4) == 0) ? rand_signed(vsh) : (p.py < 0 ? vm : -vm);
		end
		if (p.ma == 0) p.ma = 1;
		if (p.mb == 0) p.mb = 1;
		return p;
	endfunction

	// driver: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_impulses.push_back(resolve_pair(cur_pair));
				n_sent <= n_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 0;
				end else if (pending_pairs.size() > 0) begin
					cur_pair <= pending_pairs[0];
					s_tdata <= {pending_pairs[0].bb, pending_pairs[0].ba, pending_pairs[0].mb,
						pending_pairs[0].ma, pending_pairs[0].rb, pending_pairs[0].ra,
						pending_pairs[0].vy, pending_pairs[0].vx, pending_pairs[0].py,
						pending_pairs[0].px};
					s_tuser <= pending_pairs[0].bodies;
					s_tvalid <= 1;
					void'(pending_pairs.pop_front());
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
			n_err++;
		end
	endtask

	// monitor: checks results, stalls on its own pattern, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		impulse_t ex;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_res <= n_res + 1;
				if (expected_impulses.size() == 0) begin
					$error("result with no expected item pending");
					n_err++;
				end else begin
					ex = expected_impulses.pop_front();
					n_overlap += ex.overlap;
					n_valid += ex.valid;
					cmp_field("overlap", ex.overlap, m_tuser[0]);
					cmp_field("impulse_valid", ex.valid, m_tuser[1]);
					cmp_field("push_a_x", ex.pax, m_tdata[31:0]);
					cmp_field("push_a_y", ex.pay, m_tdata[63:32]);
					cmp_field("push_b_x", ex.pbx, m_tdata[95:64]);
					cmp_field("push_b_y", ex.pby, m_tdata[127:96]);
				end
			end
			if (!held && n_res >= HOLD_AT) begin
				held <= 1;
				hold_left <= HOLD_LEN;
				m_tready <= 0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= (hold_left == 1);
			end else if (phase_left > 0) begin
				phase_left <= phase_left - 1;
			end else begin
				m_tready <= !m_tready;
				phase_left <= m_tready ? $urandom_range(0, 7) : $urandom_range(1, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		// zero distance, bodies present
		pending_pairs.push_back(mk_pair(0, 0, 32'sh10000, 0, 32'h10000, 32'h10000,
			32'h10000, 32'h10000, 65536, 65536, 1));
		// zero normal velocity
		pending_pairs.push_back(mk_pair(32'sh8000, 0, 0, 0, 32'h10000, 32'h10000,
			32'h10000, 32'h20000, 32768, 16384, 1));
		// separating pair
		pending_pairs.push_back(mk_pair(32'sh8000, 32'sh4000, 32'sh10000, 32'sh10000,
			32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 1));
		// overlap without bodies
		pending_pairs.push_back(mk_pair(-32'sh8000, 32'sh4000, 32'sh10000, 0,
			32'h10000, 32'h10000, 32'h10000, 32'h10000, 65536, 0, 0));
		// just touching: not an overlap
		pending_pairs.push_back(mk_pair(32'sh20000, 0, -32'sh10000, 0, 32'h10000, 32'h10000,
			32'h10000, 32'h10000, 0, 65536, 1));
		// head-on approach along each axis and diagonal
		pending_pairs.push_back(mk_pair(32'sh10000, 0, -32'sh30000, 0, 32'h10000, 32'h10000,
			32'h10000, 32'h10000, 65536, 65536, 1));
		pending_pairs.push_back(mk_pair(0, -32'sh10000, 0, 32'sh30000, 32'h10000, 32'h10000,
			32'h30000, 32'h10000, 32768, 65536, 1));
		pending_pairs.push_back(mk_pair(-32'sh10000, -32'sh10000, 32'sh20000, 32'sh20000,
			32'h20000, 32'h20000, 1, 32'hFFFF_FFFF, 65536, 65536, 1));
		// extreme offsets and radii
		pending_pairs.push_back(mk_pair(-32'sh8000_0000, -32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			65536, 65536, 1));
		pending_pairs.push_back(mk_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000,
			-32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 65536, 1, 1));
		// saturating pushes: tiny offset, huge velocity and masses
		pending_pairs.push_back(mk_pair(1, 1, -32'sh8000_0000, -32'sh8000_0000, 31'h7FFF_FFFF,
			0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65536, 65536, 1));
		pending_pairs.push_back(mk_pair(-1, 0, 32'sh7FFF_FFFF, 0, 0, 31'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFE, 65536, 65536, 1));
		// minimum masses with zero and unit radii
		pending_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1));
		pending_pairs.push_back(mk_pair(0, 1, 0, -32'sh10000, 1, 1, 1, 1, 0, 65536, 1));
		for (int i = 0; i < N_RANDOM; i++)
			pending_pairs.push_back(rand_pair());
		n_total = pending_pairs.size();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		while (n_sent < n_total || expected_impulses.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d pairs, checked %0d results: %0d overlapping, %0d with impulse",
			n_total, n_res, n_overlap, n_valid);
		$display("one receiver hold-off of %0d cycles filled the block", HOLD_LEN);
		if (n_err == 0 && expected_impulses.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
